### hdl/hist_eq_pkg.sv
// Shared package for the histogram equalizer: widths, function codes,
// sequencer state type. No dependencies.
package hist_eq_pkg;
   localparam int unsigned PIXEL_LIMIT = 4194304;
   localparam int unsigned COUNT_W = 23;
   localparam int unsigned COUNT_MAX = 8388607;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (PIXEL_LIMIT > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(PIXEL_LIMIT);
   localparam int unsigned BINS = 256;
   localparam int unsigned ADDR_W = 8;
   localparam int unsigned NUM_W = 33;   // 510*cdf + N < 2^33
   localparam int unsigned DEN_W = 24;   // 2N

   localparam logic [1:0] FUNC_COUNT = 2'd0;
   localparam logic [1:0] FUNC_MAP   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_CNTRD = 7'b0000100,
      ST_CNTWR = 7'b0001000,
      ST_SUM   = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;
endpackage

### hdl/hist_eq_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module hist_eq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

### hdl/hist_eq_div.sv
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on hist_eq_pkg.
module hist_eq_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hist_eq_pkg::NUM_W-1:0] numer,
   input  logic [hist_eq_pkg::DEN_W-1:0] denom,
   output logic                          done,
   output logic [7:0]                    quot
);
   import hist_eq_pkg::*;
   // quotient never exceeds 255 (cdf <= N), so 8 steps suffice
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [7:0]       q_ff, q_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [NUM_W+7:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = (NUM_W+8)'(den_ff) << (cnt_ff - 4'd1);
      if (start) begin
         rem_in  = numer;
         den_in  = denom;
         q_in    = '0;
         cnt_in  = 4'd8;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({8'd0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[NUM_W-1:0];
            q_in   = {q_ff[6:0], 1'b1};
         end else begin
            q_in   = {q_ff[6:0], 1'b0};
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = busy_ff && (cnt_ff == 4'd1);
   assign quot = q_in;
endmodule

### hdl/histogram_equalizer.sv
// Histogram equalizer top level: sequencer, bin RAM, divider.
// Count: reads the bin (ST_CNTRD), writes it incremented (ST_CNTWR). Map: sums bins
// 0..pixel into the cdf, then divides (load plus 8 steps) and raises rsp_valid.
// Clear: sweeps all 256 RAM bins. After reset the same clearing pass runs, req_ready low.
// Reset is synchronous, active high; RAM contents need no reset.
// Depends on hist_eq_pkg, hist_eq_ram, hist_eq_div.
module histogram_equalizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_pixel,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_equalized,
   output logic       rsp_empty_flag
);
   import hist_eq_pkg::*;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   pix_ff, pix_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  sum_ff, sum_in;
   logic                last_ff, last_in;
   logic                rdv_ff, rdv_in;
   logic [7:0]          eq_ff, eq_in;
   logic                empty_ff, empty_in;
   logic                ram_we;
   logic [COUNT_W-1:0]  ram_wd, ram_rd;
   logic                div_start, div_done;
   logic [7:0]          div_q;
   logic [NUM_W-1:0]    numer;

   hist_eq_ram #(.WIDTH(COUNT_W), .DEPTH(BINS)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(addr_ff), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   assign numer = NUM_W'(510) * NUM_W'(sum_ff) + NUM_W'(total_ff);

   hist_eq_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(numer), .denom({total_ff, 1'b0}), .done(div_done), .quot(div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_equalized = eq_ff;
   assign rsp_empty_flag = empty_ff;

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      pix_in    = pix_ff;
      total_in  = total_ff;
      sum_in    = sum_ff;
      last_in   = 1'b0;
      rdv_in    = 1'b0;
      eq_in     = eq_ff;
      empty_in  = empty_ff;
      ram_we    = 1'b0;
      ram_wd    = ram_rd + COUNT_W'(1);
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pix_in  = req_pixel;
               addr_in = '0;
               if (req_func == FUNC_COUNT) begin
                  if (total_ff < COUNT_CAP) begin
                     addr_in  = req_pixel;
                     state_in = ST_CNTRD;
                  end
               end else if (req_func == FUNC_MAP) begin
                  if (total_ff == '0) begin
                     eq_in    = '0;
                     empty_in = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     sum_in   = '0;
                     state_in = ST_SUM;
                  end
               end else if (req_func == FUNC_CLEAR) begin
                  total_in = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            ram_we  = 1'b1;
            ram_wd  = '0;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == ADDR_W'(BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_CNTRD: state_in = ST_CNTWR;
         ST_CNTWR: begin
            ram_we   = 1'b1;
            total_in = total_ff + COUNT_W'(1);
            state_in = ST_IDLE;
         end
         ST_SUM: begin
            // rdv_ff/last_ff describe the word now on ram_rd, read from the previous addr_ff
            if (rdv_ff) begin
               sum_in = sum_ff + ram_rd;
            end
            if (last_ff) begin
               state_in = ST_DIV;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
               rdv_in  = 1'b1;
               last_in = (addr_ff == pix_ff);
            end
         end
         ST_DIV: begin
            div_start = !rdv_ff;
            rdv_in    = 1'b1;
            if (div_done) begin
               eq_in    = div_q;
               empty_in = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         total_ff <= '0;
         rdv_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         total_ff <= total_in;
         rdv_ff   <= rdv_in;
         last_ff  <= last_in;
      end
      pix_ff   <= pix_in;
      sum_ff   <= sum_in;
      eq_ff    <= eq_in;
      empty_ff <= empty_in;
   end
endmodule
